[src/depth_buffer_test_update_unit_macros.svh]
// Assertion helpers for the checker of the depth buffer block.
// Each macro takes a label, a precondition, a consequence and a message.
`ifndef DEPTH_BUFFER_TEST_UPDATE_UNIT_MACROS_SVH
`define DEPTH_BUFFER_TEST_UPDATE_UNIT_MACROS_SVH

// The consequence must hold in the same cycle as the precondition.
`define DBTU_ASSERT_SAME(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequence must hold in the cycle after the precondition.
`define DBTU_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/dbtu_pkg.sv]
package dbtu_pkg;

    localparam int WIDTH_MAX_DEFAULT  = 256;
    localparam int HEIGHT_MAX_DEFAULT = 256;
    localparam int DEPTH_BITS_DEFAULT = 32;

    localparam int COORD_BITS  = 16;
    localparam int Q_BITS      = 32;
    localparam int STATUS_BITS = 2;
    localparam int RESULT_BITS = STATUS_BITS + Q_BITS;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 9;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 1'd1;
    localparam logic [CFG_DATA_BITS-1:0]  CFG_SIZE_RESET   = 9'd256;

    localparam int MID_DEPTH    = 2;
    localparam int OUT_DEPTH    = 4;
    localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_TEST  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        OP_TEST,
        OP_READ,
        OP_WRITE,
        OP_CLEAR,
        OP_RANGE
    } op_kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_REJECT = 2'd1,
        STATUS_RANGE  = 2'd2
    } status_t;

endpackage

[src/dbtu_queue.sv]
module dbtu_queue #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           push_data,
    input  logic                       pop,
    output logic [WIDTH-1:0]           pop_data,
    output logic                       empty,
    output logic                       full,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CNT_BITS'(DEPTH));
    assign count    = count_reg;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[src/dbtu_front.sv]
module dbtu_front #(
    parameter int WIDTH_MAX  = dbtu_pkg::WIDTH_MAX_DEFAULT,
    parameter int HEIGHT_MAX = dbtu_pkg::HEIGHT_MAX_DEFAULT,
    parameter int DEPTH_BITS = dbtu_pkg::DEPTH_BITS_DEFAULT,
    parameter int ADDR_BITS  = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dbtu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dbtu_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          command,
    input  logic [dbtu_pkg::COORD_BITS-1:0]     pixel_x,
    input  logic [dbtu_pkg::COORD_BITS-1:0]     pixel_y,
    input  logic signed [dbtu_pkg::Q_BITS-1:0]  frag_depth,
    input  logic                                queue_full,
    input  logic                                init_busy,
    output logic                                q_push,
    output dbtu_pkg::op_kind_t                  q_kind,
    output logic [ADDR_BITS-1:0]                q_addr,
    output logic [DEPTH_BITS-1:0]               q_depth
);

    localparam int CB = dbtu_pkg::COORD_BITS;
    localparam int DB = dbtu_pkg::CFG_DATA_BITS;
    localparam int IDX_BITS = 2 * DB + 1;
    localparam logic [CB-1:0] WIDTH_CAP  = CB'(WIDTH_MAX);
    localparam logic [CB-1:0] HEIGHT_CAP = CB'(HEIGHT_MAX);
    localparam logic signed [63:0] FAR64  =
        signed'(64'({1'b0, {(DEPTH_BITS-1){1'b1}}}));
    localparam logic signed [63:0] NEAR64 = -FAR64 - 64'sd1;

    logic [DB-1:0]           image_width_reg, image_width_next;
    logic [DB-1:0]           image_height_reg, image_height_next;
    logic [CB-1:0]           w_ext, h_ext, w_act, h_act;
    logic                    in_range;
    logic [IDX_BITS-1:0]     idx_sum;
    logic signed [63:0]      frag64, sat64;

    assign cfg_ready = 1'b1;
    assign full      = queue_full || init_busy;
    assign q_push    = push && !full;

    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                dbtu_pkg::REG_IMAGE_WIDTH:  image_width_next  = cfg_data;
                dbtu_pkg::REG_IMAGE_HEIGHT: image_height_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= dbtu_pkg::CFG_SIZE_RESET;
            image_height_reg <= dbtu_pkg::CFG_SIZE_RESET;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
        end
    end

    // The active size is the register capped at the store geometry.
    assign w_ext    = CB'(image_width_reg);
    assign h_ext    = CB'(image_height_reg);
    assign w_act    = (w_ext > WIDTH_CAP) ? WIDTH_CAP : w_ext;
    assign h_act    = (h_ext > HEIGHT_CAP) ? HEIGHT_CAP : h_ext;
    assign in_range = (pixel_x < w_act) && (pixel_y < h_act);

    // In range, x, y and the width all fit the register width.
    assign idx_sum = IDX_BITS'(pixel_x[DB-1:0])
                   + IDX_BITS'(w_act[DB-1:0]) * IDX_BITS'(pixel_y[DB-1:0]);
    assign q_addr  = ADDR_BITS'(idx_sum);

    assign frag64  = 64'(frag_depth);
    assign sat64   = (frag64 > FAR64) ? FAR64 : ((frag64 < NEAR64) ? NEAR64 : frag64);
    assign q_depth = sat64[DEPTH_BITS-1:0];

    always_comb
    begin
        case (dbtu_pkg::cmd_t'(command))
            dbtu_pkg::CMD_CLEAR: q_kind = dbtu_pkg::OP_CLEAR;
            dbtu_pkg::CMD_TEST:  q_kind = in_range ? dbtu_pkg::OP_TEST  : dbtu_pkg::OP_RANGE;
            dbtu_pkg::CMD_READ:  q_kind = in_range ? dbtu_pkg::OP_READ  : dbtu_pkg::OP_RANGE;
            dbtu_pkg::CMD_WRITE: q_kind = in_range ? dbtu_pkg::OP_WRITE : dbtu_pkg::OP_RANGE;
            default:             q_kind = dbtu_pkg::OP_RANGE;
        endcase
    end

endmodule

[src/dbtu_back.sv]
module dbtu_back #(
    parameter int WIDTH_MAX  = dbtu_pkg::WIDTH_MAX_DEFAULT,
    parameter int HEIGHT_MAX = dbtu_pkg::HEIGHT_MAX_DEFAULT,
    parameter int DEPTH_BITS = dbtu_pkg::DEPTH_BITS_DEFAULT,
    parameter int ADDR_BITS  = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              op_valid,
    output logic                              op_pop,
    input  dbtu_pkg::op_kind_t                op_kind,
    input  logic [ADDR_BITS-1:0]              op_addr,
    input  logic [DEPTH_BITS-1:0]             op_depth,
    input  logic [dbtu_pkg::OUT_CNT_BITS-1:0] out_count,
    output logic                              out_push,
    output dbtu_pkg::status_t                 out_status,
    output logic [dbtu_pkg::Q_BITS-1:0]       out_depth,
    output logic                              init_busy
);

    localparam int STORE_SIZE = WIDTH_MAX * HEIGHT_MAX;
    localparam int CB = dbtu_pkg::OUT_CNT_BITS;
    localparam logic [ADDR_BITS-1:0]  SWEEP_LAST = ADDR_BITS'(STORE_SIZE - 1);
    localparam logic [DEPTH_BITS-1:0] FAR_VALUE  = {1'b0, {(DEPTH_BITS-1){1'b1}}};
    localparam logic signed [63:0]    Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0]    Q_MIN = -64'sd2147483648;

    typedef enum logic [1:0] {
        S_INIT,
        S_RUN,
        S_CLEAR
    } state_t;

    state_t                  state_reg, state_next;
    logic [ADDR_BITS-1:0]    clr_addr_reg, clr_addr_next;
    logic                    b_valid_reg, b_valid_next;
    logic                    fwd_valid_reg, fwd_valid_next;
    dbtu_pkg::op_kind_t      b_kind_reg;
    logic [ADDR_BITS-1:0]    b_addr_reg;
    logic [DEPTH_BITS-1:0]   b_depth_reg;
    logic [ADDR_BITS-1:0]    fwd_addr_reg;
    logic [DEPTH_BITS-1:0]   fwd_data_reg;
    logic [DEPTH_BITS-1:0]   rd_data_reg;
    logic [DEPTH_BITS-1:0]   depth_mem [STORE_SIZE];

    logic [CB:0]             used;
    logic                    room;
    logic                    issue;
    logic                    sweeping;
    logic                    sweep_last;
    logic [DEPTH_BITS-1:0]   cur;
    logic                    deeper;
    logic                    b_write;
    logic                    we;
    logic [ADDR_BITS-1:0]    wa;
    logic [DEPTH_BITS-1:0]   wd;
    logic signed [63:0]      cur64;
    logic signed [63:0]      cur_sat;

    // Issued items but clears push a result next cycle, so stage B counts as used.
    assign used  = (CB+1)'(out_count) + (CB+1)'(b_valid_reg);
    assign room  = (used < (CB+1)'(dbtu_pkg::OUT_DEPTH));
    assign issue = (state_reg == S_RUN) && op_valid && room;
    assign op_pop = issue;

    assign sweeping   = (state_reg == S_INIT) || (state_reg == S_CLEAR);
    assign sweep_last = (clr_addr_reg == SWEEP_LAST);
    assign init_busy  = (state_reg == S_INIT);

    // The write of the previous cycle is not yet visible in the read data.
    assign cur    = (fwd_valid_reg && (fwd_addr_reg == b_addr_reg)) ? fwd_data_reg
                                                                    : rd_data_reg;
    assign deeper = signed'(b_depth_reg) > signed'(cur);
    assign b_write = b_valid_reg && ((b_kind_reg == dbtu_pkg::OP_WRITE)
                   || ((b_kind_reg == dbtu_pkg::OP_TEST) && !deeper));

    assign we = b_write || sweeping;
    assign wa = sweeping ? clr_addr_reg : b_addr_reg;
    assign wd = sweeping ? FAR_VALUE : b_depth_reg;

    assign cur64   = 64'(signed'(cur));
    assign cur_sat = (cur64 > Q_MAX) ? Q_MAX : ((cur64 < Q_MIN) ? Q_MIN : cur64);

    assign out_push = b_valid_reg || ((state_reg == S_CLEAR) && sweep_last);

    always_comb
    begin
        out_status = dbtu_pkg::STATUS_OK;
        out_depth  = cur_sat[dbtu_pkg::Q_BITS-1:0];
        if (!b_valid_reg)
        begin
            out_depth = '0;
        end
        else
        begin
            case (b_kind_reg)
                dbtu_pkg::OP_TEST:
                begin
                    out_status = deeper ? dbtu_pkg::STATUS_REJECT : dbtu_pkg::STATUS_OK;
                end
                dbtu_pkg::OP_READ, dbtu_pkg::OP_WRITE:
                begin
                    out_status = dbtu_pkg::STATUS_OK;
                end
                default:
                begin
                    out_status = dbtu_pkg::STATUS_RANGE;
                    out_depth  = '0;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        b_valid_next   = issue && (op_kind != dbtu_pkg::OP_CLEAR);
        fwd_valid_next = b_write;
        case (state_reg)
            S_INIT, S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (sweep_last)
                begin
                    state_next    = S_RUN;
                    clr_addr_next = '0;
                end
            end
            S_RUN:
            begin
                if (issue && (op_kind == dbtu_pkg::OP_CLEAR))
                begin
                    state_next    = S_CLEAR;
                    clr_addr_next = '0;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            clr_addr_reg  <= '0;
            b_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            b_valid_reg   <= b_valid_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_kind_reg  <= op_kind;
            b_addr_reg  <= op_addr;
            b_depth_reg <= op_depth;
        end
        fwd_addr_reg <= b_addr_reg;
        fwd_data_reg <= b_depth_reg;
    end

    // Read-first store: a read and a write to one address see the old entry.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            depth_mem[wa] <= wd;
        end
        if (issue)
        begin
            rd_data_reg <= depth_mem[op_addr];
        end
    end

endmodule

[src/depth_buffer_test_update_unit.sv]
// Channel   Handshake              Payload
// --------  ---------------------  ----------------------------------------------
// command   push / full            command, pixel_x, pixel_y, frag_depth
// result    pop / empty            status, stored_depth
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One command beat is taken per cycle while full is low; its result passes the
// middle queue and stage B. Throughput rests on the read-first depth store, with
// a read and a write port and the previous beat's write forwarded around it.
// A clear command sweeps the store one entry per cycle, over its WIDTH_MAX *
// HEIGHT_MAX entries (65536 at the defaults), and later beats wait behind it.
// After reset the same sweep runs with full held high; config writes still land.
// A stalled result side backs up through a four-entry result queue into full.
module depth_buffer_test_update_unit #(
    parameter int WIDTH_MAX  = dbtu_pkg::WIDTH_MAX_DEFAULT,
    parameter int HEIGHT_MAX = dbtu_pkg::HEIGHT_MAX_DEFAULT,
    parameter int DEPTH_BITS = dbtu_pkg::DEPTH_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dbtu_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dbtu_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic [1:0]                          command,
    input  logic [dbtu_pkg::COORD_BITS-1:0]     pixel_x,
    input  logic [dbtu_pkg::COORD_BITS-1:0]     pixel_y,
    input  logic signed [dbtu_pkg::Q_BITS-1:0]  frag_depth,
    output logic                                empty,
    input  logic                                pop,
    output logic [dbtu_pkg::STATUS_BITS-1:0]    status,
    output logic signed [dbtu_pkg::Q_BITS-1:0]  stored_depth
);

    // The store holds one entry per pixel of the largest image, row by row.
    localparam int STORE_SIZE = WIDTH_MAX * HEIGHT_MAX;
    localparam int ADDR_BITS  = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int KIND_BITS  = $bits(dbtu_pkg::op_kind_t);
    localparam int MID_BITS   = KIND_BITS + ADDR_BITS + DEPTH_BITS;
    localparam int RB         = dbtu_pkg::RESULT_BITS;
    localparam int QB         = dbtu_pkg::Q_BITS;

    // Front side: classified command on its way into the middle queue.
    logic                              q_push;
    dbtu_pkg::op_kind_t                q_kind;
    logic [ADDR_BITS-1:0]              q_addr;
    logic [DEPTH_BITS-1:0]             q_depth;
    logic                              mid_full;
    logic                              mid_empty;
    logic [MID_BITS-1:0]               mid_data;

    // Back side: command taken from the middle queue.
    logic                              op_pop;
    logic [KIND_BITS-1:0]              op_kind_bits;
    dbtu_pkg::op_kind_t                op_kind;
    logic [ADDR_BITS-1:0]              op_addr;
    logic [DEPTH_BITS-1:0]             op_depth;
    logic                              init_busy;

    // Results on their way out.
    logic                              out_push;
    dbtu_pkg::status_t                 out_status;
    logic [QB-1:0]                     out_depth;
    logic [RB-1:0]                     out_data;
    logic [dbtu_pkg::OUT_CNT_BITS-1:0] out_count;

    // The front checks bounds, forms the row-major address and saturates the depth,
    // so the back only has to read, compare and write.
    dbtu_front #(
        .WIDTH_MAX  (WIDTH_MAX),
        .HEIGHT_MAX (HEIGHT_MAX),
        .DEPTH_BITS (DEPTH_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push       (push),
        .full       (full),
        .command    (command),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .frag_depth (frag_depth),
        .queue_full (mid_full),
        .init_busy  (init_busy),
        .q_push     (q_push),
        .q_kind     (q_kind),
        .q_addr     (q_addr),
        .q_depth    (q_depth)
    );

    // The middle queue lets the front keep accepting while the back sweeps
    // for a clear or waits for room in the result queue.
    dbtu_queue #(
        .DEPTH (dbtu_pkg::MID_DEPTH),
        .WIDTH (MID_BITS)
    ) u_mid_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({q_kind, q_addr, q_depth}),
        .pop       (op_pop),
        .pop_data  (mid_data),
        .empty     (mid_empty),
        .full      (mid_full),
        .count     ()
    );

    assign {op_kind_bits, op_addr, op_depth} = mid_data;
    assign op_kind = dbtu_pkg::op_kind_t'(op_kind_bits);

    // The back owns the depth store, its reset sweep and its clear sweep.
    dbtu_back #(
        .WIDTH_MAX  (WIDTH_MAX),
        .HEIGHT_MAX (HEIGHT_MAX),
        .DEPTH_BITS (DEPTH_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .op_valid   (!mid_empty),
        .op_pop     (op_pop),
        .op_kind    (op_kind),
        .op_addr    (op_addr),
        .op_depth   (op_depth),
        .out_count  (out_count),
        .out_push   (out_push),
        .out_status (out_status),
        .out_depth  (out_depth),
        .init_busy  (init_busy)
    );

    assign out_data = {out_status, out_depth};

    // The back only issues a command when its result is sure to fit here.
    dbtu_queue #(
        .DEPTH (dbtu_pkg::OUT_DEPTH),
        .WIDTH (RB)
    ) u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (out_data),
        .pop       (pop),
        .pop_data  ({status, stored_depth}),
        .empty     (empty),
        .full      (),
        .count     (out_count)
    );

endmodule

[src/dbtu_checker.sv]
`include "depth_buffer_test_update_unit_macros.svh"

module dbtu_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             push,
    input logic                             full,
    input logic                             pop,
    input logic                             empty,
    input logic [dbtu_pkg::STATUS_BITS-1:0] status,
    input logic signed [dbtu_pkg::Q_BITS-1:0] stored_depth
);

    // Commands accepted whose results have not yet been taken.
    logic [3:0] pending_reg, pending_next;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = push && !full;
    assign out_beat = pop && !empty;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_beat && !out_beat)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_beat && !in_beat)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `DBTU_ASSERT_NEXT(a_result_held, (!empty && !pop), (!empty && $stable(status) && $stable(stored_depth)), "result changed while stalled")
    `DBTU_ASSERT_SAME(a_no_invented_result, !empty, (pending_reg != 4'd0), "result shown with no command outstanding")
    `DBTU_ASSERT_SAME(a_pending_bound, 1'b1, (pending_reg <= 4'd6), "more commands outstanding than the queues hold")
    `DBTU_ASSERT_SAME(a_status_code, !empty, (status != 2'd3), "undefined status code on the result side")

endmodule

bind depth_buffer_test_update_unit dbtu_checker u_checker (.*);

[test/tb.sv]
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dbtu_pkg::*;

    typedef logic signed [Q_BITS-1:0] depth_t;

    localparam depth_t FAR_DEPTH  = 32'sh7FFF_FFFF;
    localparam depth_t NEAR_DEPTH = 32'sh8000_0000;
    localparam int     MAP_SIZE   = WIDTH_MAX_DEFAULT * HEIGHT_MAX_DEFAULT;

    // One expected result beat: the status and the depth held before the command.
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        depth_t                 depth;
    } depth_result_t;

    // The board keeps its own copy of the depth map and the image size registers.
    // Every accepted command beat is applied to that copy at once, and the result
    // that it must produce is queued. Result beats are compared in order.
    class depth_buffer_board;
        logic [CFG_DATA_BITS-1:0] width_reg;
        logic [CFG_DATA_BITS-1:0] height_reg;
        depth_t                   depth_map [MAP_SIZE];
        depth_result_t            pending_results [$];
        int unsigned              errors;

        function new();
            width_reg  = CFG_SIZE_RESET;
            height_reg = CFG_SIZE_RESET;
            errors     = 0;
            foreach (depth_map[i]) depth_map[i] = FAR_DEPTH;
        endfunction

        function void write_register(logic [CFG_INDEX_BITS-1:0] index,
                                     logic [CFG_DATA_BITS-1:0] value);
            if (index == REG_IMAGE_WIDTH) width_reg = value;
            else if (index == REG_IMAGE_HEIGHT) height_reg = value;
        endfunction

        // Register values above the store size are capped to it.
        function int unsigned active_width();
            return (width_reg > WIDTH_MAX_DEFAULT) ? WIDTH_MAX_DEFAULT : width_reg;
        endfunction

        function int unsigned active_height();
            return (height_reg > HEIGHT_MAX_DEFAULT) ? HEIGHT_MAX_DEFAULT : height_reg;
        endfunction

        // Entry of pixel (x, y), or -1 when the pixel lies outside the image.
        function int pixel_slot(logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y);
            if (x >= active_width() || y >= active_height()) return -1;
            return x + active_width() * y;
        endfunction

        function void apply_command(cmd_t cmd, logic [COORD_BITS-1:0] x,
                                    logic [COORD_BITS-1:0] y, depth_t frag);
            depth_result_t want;
            int            slot;
            want.status = STATUS_OK;
            want.depth  = '0;
            slot = pixel_slot(x, y);
            if (cmd == CMD_CLEAR)
            begin
                foreach (depth_map[i]) depth_map[i] = FAR_DEPTH;
            end
            else if (slot < 0)
            begin
                want.status = STATUS_RANGE;
            end
            else
            begin
                want.depth = depth_map[slot];
                // A fragment at equal depth passes and is stored.
                if (cmd == CMD_TEST)
                begin
                    if (depth_map[slot] < frag) want.status = STATUS_REJECT;
                    else depth_map[slot] = frag;
                end
                else if (cmd == CMD_WRITE)
                begin
                    depth_map[slot] = frag;
                end
            end
            pending_results.push_back(want);
        endfunction

        function void check_result(logic [STATUS_BITS-1:0] got_status, depth_t got_depth);
            depth_result_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat: expected none, actual status %0d depth %h",
                         $time, got_status, got_depth);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got_status !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, got_status);
                errors++;
            end
            if (got_depth !== want.depth)
            begin
                $display("%0t: stored_depth mismatch: expected %h actual %h",
                         $time, want.depth, got_depth);
                errors++;
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]   cfg_data = '0;
    logic                       push = 1'b0;
    logic                       full;
    logic [1:0]                 command = CMD_READ;
    logic [COORD_BITS-1:0]      pixel_x = '0;
    logic [COORD_BITS-1:0]      pixel_y = '0;
    depth_t                     frag_depth = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic [STATUS_BITS-1:0]     status;
    depth_t                     stored_depth;

    depth_buffer_board board = new();

    // Upper bounds of the per-beat idle draws of each side; a bound of zero
    // gives a stretch at full rate on that side.
    int unsigned push_gap_max = 11;
    int unsigned pop_gap_max  = 11;

    // Every clear costs a sweep of the whole store, so only a couple of them
    // are allowed in the random part.
    int unsigned clears_left = 2;

    depth_buffer_test_update_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .push         (push),
        .full         (full),
        .command      (command),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .frag_depth   (frag_depth),
        .empty        (empty),
        .pop          (pop),
        .status       (status),
        .stored_depth (stored_depth)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Inputs change on the falling edge only; beats are taken on the rising edge.
    // Push is left high after an accepted beat, so that a following beat with no
    // gap goes in on the very next edge without push dropping in between.
    task automatic send_command(cmd_t cmd, logic [COORD_BITS-1:0] x,
                                logic [COORD_BITS-1:0] y, depth_t frag);
        int unsigned gap;
        gap = $urandom_range(0, push_gap_max);
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push       <= 1'b1;
        command    <= cmd;
        pixel_x    <= x;
        pixel_y    <= y;
        frag_depth <= frag;
        @(posedge clk);
        while (full) @(posedge clk);
        board.apply_command(cmd, x, y, frag);
    endtask

    // Stop sending and hold off until every queued result beat has come back.
    task automatic wait_drained();
        @(negedge clk);
        push <= 1'b0;
        while (board.pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_BITS-1:0] index,
                                  logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.write_register(index, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // The block must be idle here: every caller drains the result side first.
    task automatic set_image_size(logic [CFG_DATA_BITS-1:0] w, logic [CFG_DATA_BITS-1:0] h);
        write_register(REG_IMAGE_WIDTH, w);
        write_register(REG_IMAGE_HEIGHT, h);
    endtask

    // Random commands for one image size. Most beats land inside the image, and
    // about a third of them hit the previous pixel again, which drives the
    // write forwarding in the block on back-to-back beats. Depths are drawn
    // equal to or next to the stored depth often enough that the depth test
    // goes both ways, including the equal case.
    task automatic run_random_phase(int unsigned count);
        cmd_t                  cmd;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] last_x;
        logic [COORD_BITS-1:0] last_y;
        depth_t                frag;
        depth_t                base;
        int                    slot;
        int unsigned           r;
        int unsigned           aw;
        int unsigned           ah;
        last_x = '0;
        last_y = '0;
        aw = board.active_width();
        ah = board.active_height();
        repeat (count)
        begin
            r = $urandom_range(0, 9);
            if (clears_left > 0 && $urandom_range(0, 299) == 0)
            begin
                cmd = CMD_CLEAR;
                clears_left--;
            end
            else if (r < 6)
            begin
                cmd = CMD_TEST;
            end
            else if (r < 8)
            begin
                cmd = CMD_WRITE;
            end
            else
            begin
                cmd = CMD_READ;
            end

            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                x = last_x;
                y = last_y;
            end
            else if (r < 42 || aw == 0 || ah == 0)
            begin
                // Out of range on one axis or both; the random halves also
                // exercise every bit of the coordinate fields.
                x = COORD_BITS'($urandom());
                y = COORD_BITS'($urandom());
                if (aw != 0 && r[0]) x = COORD_BITS'($urandom_range(0, aw - 1));
                else if (ah != 0 && r[1]) y = COORD_BITS'($urandom_range(0, ah - 1));
            end
            else
            begin
                x = COORD_BITS'($urandom_range(0, aw - 1));
                y = COORD_BITS'($urandom_range(0, ah - 1));
            end
            last_x = x;
            last_y = y;

            slot = board.pixel_slot(x, y);
            base = (slot >= 0) ? board.depth_map[slot] : depth_t'($urandom());
            case ($urandom_range(0, 9))
                0, 1, 2: frag = $urandom();
                3, 4:    frag = base;
                5, 6:    frag = base + (int'($urandom_range(0, 6)) - 3);
                7:       frag = $urandom_range(0, 1) ? FAR_DEPTH : NEAR_DEPTH;
                default: frag = int'($urandom_range(0, 32'h20_0000)) - 32'sh10_0000;
            endcase

            send_command(cmd, x, y, frag);

            // Now and then the sender holds off until the block has drained.
            if ($urandom_range(0, 99) == 0) wait_drained();
        end
    endtask

    // Result side: pop may drop for a random stall after each beat.
    // Pop is written once per falling edge, so it never glitches low between
    // two beats taken at full rate.
    initial
    begin : result_side
        int unsigned stall_left;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
            begin
                pop <= 1'b1;
            end
            @(posedge clk);
            if (pop && !empty)
            begin
                board.check_result(status, stored_depth);
                stall_left = $urandom_range(0, pop_gap_max);
            end
        end
    end

    // Image sizes and idle bounds of the random phases. Sizes cover the smallest
    // image, full rows and columns, odd shapes and register values beyond the
    // store, which the block caps.
    int unsigned phase_w     [9] = '{256, 1, 3, 16, 256, 1, 7, 511, 2};
    int unsigned phase_h     [9] = '{256, 1, 5, 16, 1, 256, 200, 300, 2};
    int unsigned phase_push  [9] = '{11, 0, 11, 0, 11, 0, 11, 0, 11};
    int unsigned phase_pop   [9] = '{11, 0, 0, 11, 11, 0, 11, 11, 11};
    int unsigned phase_count [9] = '{150, 60, 140, 150, 120, 120, 140, 120, 100};

    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The block sweeps its store after reset with full held high; the
        // register writes land in the meantime and the first beat waits.
        set_image_size(9'd256, 9'd256);

        // Directed part on the full image: a fresh pixel reads far, a fragment
        // at the far depth ties and passes, then the nearest and farthest depths.
        send_command(CMD_READ, 16'd0, 16'd0, 32'sd0);
        send_command(CMD_TEST, 16'd0, 16'd0, FAR_DEPTH);
        send_command(CMD_TEST, 16'd0, 16'd0, NEAR_DEPTH);
        send_command(CMD_TEST, 16'd0, 16'd0, FAR_DEPTH);
        send_command(CMD_TEST, 16'd0, 16'd0, NEAR_DEPTH);
        // The far corner: a write, then one fragment just behind and one just
        // in front of the written depth.
        send_command(CMD_WRITE, 16'd255, 16'd255, 32'sh1234_5678);
        send_command(CMD_TEST, 16'd255, 16'd255, 32'sh1234_5679);
        send_command(CMD_TEST, 16'd255, 16'd255, 32'sh1234_5677);
        send_command(CMD_READ, 16'd255, 16'd255, 32'sd0);
        // Coordinates just outside and far outside the image, on test, read and write.
        send_command(CMD_TEST, 16'd256, 16'd0, 32'sd0);
        send_command(CMD_READ, 16'd0, 16'd256, 32'sd0);
        send_command(CMD_WRITE, 16'hFFFF, 16'hFFFF, NEAR_DEPTH);
        send_command(CMD_READ, 16'd255, 16'd255, 32'sd0);
        // Clear ignores its coordinates and brings every pixel back to far.
        send_command(CMD_CLEAR, 16'hFFFF, 16'h1234, NEAR_DEPTH);
        send_command(CMD_READ, 16'd0, 16'd0, 32'sd0);
        send_command(CMD_READ, 16'd255, 16'd255, 32'sd0);

        // Smallest image: only pixel (0, 0) exists.
        wait_drained();
        set_image_size(9'd1, 9'd1);
        send_command(CMD_TEST, 16'd0, 16'd0, 32'sh0001_8000);
        send_command(CMD_READ, 16'd1, 16'd0, 32'sd0);
        send_command(CMD_READ, 16'd0, 16'd1, 32'sd0);

        // A zero width puts every pixel out of range.
        wait_drained();
        set_image_size(9'd0, 9'd5);
        send_command(CMD_TEST, 16'd0, 16'd0, 32'sd0);

        // Register values beyond the store are capped at its size.
        wait_drained();
        set_image_size(9'd511, 9'd300);
        send_command(CMD_WRITE, 16'd255, 16'd100, 32'sh0000_0100);
        send_command(CMD_READ, 16'd255, 16'd100, 32'sd0);
        send_command(CMD_READ, 16'd256, 16'd0, 32'sd0);
        send_command(CMD_READ, 16'd0, 16'd256, 32'sd0);

        // Random phases, each on an idle block with a fresh image size.
        for (int p = 0; p < 9; p++)
        begin
            wait_drained();
            set_image_size(CFG_DATA_BITS'(phase_w[p]), CFG_DATA_BITS'(phase_h[p]));
            push_gap_max = phase_push[p];
            pop_gap_max  = phase_pop[p];
            run_random_phase(phase_count[p]);
        end

        // Wind down: let the last results through, then wait on with no traffic to
        // catch any stray beat behind them.
        pop_gap_max = 11;
        wait_drained();
        repeat (10) @(posedge clk);
        if (board.errors == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // A stuck handshake ends the run here. The bound allows for several
    // full-store sweeps on top of the slowest pace of both sides.
    initial
    begin : watchdog
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
